// File: hw/rtl/sogc_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helper functions of the segment overlap grid counter.
// Depends on nothing; every other file of the block but sogc_ram imports it.
package sogc_pkg;

	localparam int COORD_W   = 10;
	localparam int TOTAL_W   = 21;
	localparam int CNT_W     = 2;
	localparam int GRID_SIZE = 1024;
	localparam int CELLS     = GRID_SIZE * GRID_SIZE;
	localparam int ADDR_W    = $clog2(CELLS);
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [TOTAL_W-1:0] total_t;
	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [CNT_W-1:0]   cnt_t;

	localparam total_t TOTAL_MAX = {TOTAL_W{1'b1}};
	localparam cnt_t   CNT_MAX   = {CNT_W{1'b1}};
	localparam cnt_t   CNT_ONE   = cnt_t'(1);

	// One classified segment: the fixed coordinate and the inclusive run along the other axis.
	typedef struct packed {
		logic   diag;
		logic   vert;
		coord_t fixed;
		coord_t lo;
		coord_t hi;
	} cmd_t;

	// Head of the command queue as the back end sees it.
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} queue_t;

	// Back end control toward the front end.
	typedef struct packed {
		logic pop;
		logic clearing;
	} back_ctl_t;

	function automatic logic in_grid(input coord_t c);
		return int'(c) < GRID_SIZE;
	endfunction

	function automatic addr_t cell_addr(input coord_t x, input coord_t y);
		return addr_t'(int'(y) * GRID_SIZE + int'(x));
	endfunction

endpackage

// File: hw/rtl/sogc_seg_if.sv
`timescale 1ns / 1ps
// Valid/ready channel that carries one segment word (two endpoints).
// Depends on sogc_pkg.
interface sogc_seg_if;
	import sogc_pkg::*;

	logic   valid;
	logic   ready;
	coord_t start_x;
	coord_t start_y;
	coord_t end_x;
	coord_t end_y;

	modport source (output valid, output start_x, output start_y, output end_x,
		output end_y, input ready);
	modport sink (input valid, input start_x, input start_y, input end_x,
		input end_y, output ready);
endinterface

// File: hw/rtl/sogc_res_if.sv
`timescale 1ns / 1ps
// Valid/ready channel that carries one result word (overlap total and diagonal flag).
// Depends on sogc_pkg.
interface sogc_res_if;
	import sogc_pkg::*;

	logic   valid;
	logic   ready;
	total_t overlap_cells;
	logic   skipped_diagonal;

	modport source (output valid, output overlap_cells, output skipped_diagonal, input ready);
	modport sink (input valid, input overlap_cells, input skipped_diagonal, output ready);
endinterface

// File: hw/rtl/sogc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module sogc_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// File: hw/rtl/sogc_front.sv
`timescale 1ns / 1ps
// Front end: accepts segment words, classifies them and queues the commands.
// Depends on sogc_pkg and sogc_seg_if.
module sogc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	sogc_seg_if.sink             seg,
	input  sogc_pkg::back_ctl_t  ctl,
	output sogc_pkg::queue_t     head
);
	import sogc_pkg::*;

	cmd_t              cmd_in;
	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;

	// A segment whose endpoints coincide takes the vertical path with lo equal to hi.
	always_comb begin
		cmd_in = '0;
		if (seg.start_x == seg.end_x) begin
			cmd_in.vert  = 1'b1;
			cmd_in.fixed = seg.start_x;
			cmd_in.lo    = (seg.start_y < seg.end_y) ? seg.start_y : seg.end_y;
			cmd_in.hi    = (seg.start_y < seg.end_y) ? seg.end_y : seg.start_y;
		end else if (seg.start_y == seg.end_y) begin
			cmd_in.fixed = seg.start_y;
			cmd_in.lo    = (seg.start_x < seg.end_x) ? seg.start_x : seg.end_x;
			cmd_in.hi    = (seg.start_x < seg.end_x) ? seg.end_x : seg.start_x;
		end else begin
			cmd_in.diag = 1'b1;
		end
	end

	assign seg.ready  = (cnt_q != QCNT_W'(QDEPTH)) && !ctl.clearing;
	assign push       = seg.valid && seg.ready;
	assign head.valid = (cnt_q != '0);
	assign head.cmd   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (ctl.pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !ctl.pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && ctl.pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= cmd_in;
		end
	end
endmodule

// File: hw/rtl/sogc_back.sv
`timescale 1ns / 1ps
// Back end: clears the coverage store, walks each segment one cell a cycle and
// keeps the overlap total and the result register. Depends on sogc_pkg, sogc_res_if, sogc_ram.
module sogc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sogc_pkg::queue_t     head,
	output sogc_pkg::back_ctl_t  ctl,
	sogc_res_if.source           res
);
	import sogc_pkg::*;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_RUN   = 3'd2;
	localparam logic [2:0] ST_FLUSH = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	logic [2:0] state_q;
	addr_t      clr_q;
	coord_t     cur_q;
	coord_t     hi_q;
	coord_t     fix_q;
	logic       vert_q;
	logic       valid_s1;
	addr_t      addr_s1;
	total_t     total_q;
	logic       out_valid_q;
	total_t     out_total_q;
	logic       out_diag_q;

	coord_t cx;
	coord_t cy;
	logic   rd_en;
	addr_t  rd_addr;
	cnt_t   rd_cnt;
	logic   upd_we;
	logic   mem_we;
	addr_t  mem_waddr;
	cnt_t   mem_wdata;
	logic   pop;
	logic   load_diag;

	assign cx      = vert_q ? fix_q : cur_q;
	assign cy      = vert_q ? cur_q : fix_q;
	assign rd_en   = (state_q == ST_RUN) && in_grid(cx) && in_grid(cy);
	assign rd_addr = cell_addr(cx, cy);

	// A saturated cell is left alone; the others go up by one.
	assign upd_we    = valid_s1 && (rd_cnt != CNT_MAX);
	assign mem_we    = (state_q == ST_CLEAR) || upd_we;
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : addr_s1;
	assign mem_wdata = (state_q == ST_CLEAR) ? '0 : rd_cnt + 1'b1;

	sogc_ram #(
		.WIDTH(CNT_W),
		.DEPTH(CELLS)
	) u_cov (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_cnt)
	);

	// A result word that leaves in this cycle frees the result register for the next command.
	assign pop          = (state_q == ST_IDLE) && head.valid && (!out_valid_q || res.ready);
	assign load_diag    = pop && head.cmd.diag;
	assign ctl.pop      = pop;
	assign ctl.clearing = (state_q == ST_CLEAR);

	assign res.valid            = out_valid_q;
	assign res.overlap_cells    = out_total_q;
	assign res.skipped_diagonal = out_diag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			valid_s1    <= 1'b0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= rd_en;
			if (upd_we && (rd_cnt == CNT_ONE) && (total_q != TOTAL_MAX)) begin
				total_q <= total_q + 1'b1;
			end
			if (load_diag || (state_q == ST_OUT)) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == addr_t'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop && !head.cmd.diag) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cur_q == hi_q) begin
						state_q <= ST_FLUSH;
					end
				end
				// The last cell's write and total update land in this cycle.
				ST_FLUSH: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= rd_addr;
		if (pop) begin
			cur_q  <= head.cmd.lo;
			hi_q   <= head.cmd.hi;
			fix_q  <= head.cmd.fixed;
			vert_q <= head.cmd.vert;
		end else if (state_q == ST_RUN) begin
			cur_q <= cur_q + 1'b1;
		end
		if (load_diag) begin
			out_total_q <= total_q;
			out_diag_q  <= 1'b1;
		end else if (state_q == ST_OUT) begin
			out_total_q <= total_q;
			out_diag_q  <= 1'b0;
		end
	end
endmodule

// File: hw/rtl/segment_overlap_grid_counter_unit.sv
`timescale 1ns / 1ps
// Segment overlap grid counter: one result word for every segment word.
// A straight segment occupies the cell walker through its RUN, FLUSH and OUT states (one coverage RAM
// read-modify-write per cell in RUN) and its result word is loaded into the result register in OUT;
// a diagonal one is loaded into the result register straight from IDLE as it is taken.
// After reset the coverage RAM is cleared one cell a cycle, all GRID_SIZE * GRID_SIZE cells,
// 1,048,576 at a grid of 1024, during which no segment word is accepted.
module segment_overlap_grid_counter_unit (
	input logic        clk,
	input logic        arst_n,
	sogc_seg_if.sink   seg,
	sogc_res_if.source res
);
	import sogc_pkg::*;

	back_ctl_t ctl;
	queue_t    head;

	sogc_front u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.seg   (seg),
		.ctl   (ctl),
		.head  (head)
	);

	sogc_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (head),
		.ctl   (ctl),
		.res   (res)
	);
endmodule
